/* hw/rtl/sba_pkg.sv */
package sba_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 16;
    localparam int STS_W  = 3;
    localparam int GNT_W  = 6;
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 7;
    localparam int STR_W  = 10;
    localparam int CFGI_W = 2;
    localparam int PROD_W = IDX_W + STR_W;

    // group width of the two-step free-slot search
    localparam int GRP_W  = 8;
    localparam int LOW_W  = 3;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd2;
    localparam logic [OP_W-1:0] OP_HANDLE = 2'd3;

    localparam logic [STS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STS_W-1:0] ST_DISABLED  = 3'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STS_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [STS_W-1:0] ST_NOT_BUSY  = 3'd4;

    localparam logic [CFGI_W-1:0] CFG_ENABLED  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_CAPACITY = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_STRIDE   = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_BASE     = 2'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic mul;
        logic emit;
    } t_ctrl;

endpackage

/* hw/rtl/slot_bitmap_allocator.sv */
// A request taken while idle passes through its steps in order (search, decide,
// multiply, add into the output register) before its result strobe.
// A new request is taken only once the last is through; busy drops during the
// strobe cycle so the next start is taken then. Results cannot be stalled by
// the receiver. Reset (synchronous, active low) clears the busy map, the busy
// count and all configuration registers; the config port is always ready.
module slot_bitmap_allocator #(
    parameter int SLOTS = sba_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sba_pkg::OP_W-1:0]      i_operation,
    input  logic [sba_pkg::IDX_W-1:0]     i_slot_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sba_pkg::CFGI_W-1:0]    i_cfg_index,
    input  logic [sba_pkg::ADDR_W-1:0]    i_cfg_data,
    output logic                          o_strobe,
    output logic [sba_pkg::STS_W-1:0]     o_status,
    output logic [sba_pkg::GNT_W-1:0]     o_granted_slot,
    output logic [sba_pkg::ADDR_W-1:0]    o_handle_address,
    output logic [sba_pkg::CNT_W-1:0]     o_allocated_count,
    output logic [sba_pkg::CNT_W-1:0]     o_remaining_count
);

    sba_pkg::t_ctrl ctrl;

    assign o_cfg_ready = 1'b1;

    sba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_ctrl   (ctrl)
    );

    sba_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .i_operation       (i_operation),
        .i_slot_index      (i_slot_index),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_handle_address  (o_handle_address),
        .o_allocated_count (o_allocated_count),
        .o_remaining_count (o_remaining_count)
    );

endmodule

/* hw/rtl/sba_ctrl.sv */
module sba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_strobe,
    output sba_pkg::t_ctrl o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_MUL,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: n_state = S_EXEC;
            S_EXEC: n_state = S_MUL;
            S_MUL:  n_state = S_EMIT;
            S_EMIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_EMIT);
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_ctrl.load = (r_state == S_IDLE) && i_start;
    assign o_ctrl.scan = (r_state == S_SCAN);
    assign o_ctrl.exec = (r_state == S_EXEC);
    assign o_ctrl.mul  = (r_state == S_MUL);
    assign o_ctrl.emit = (r_state == S_EMIT);

endmodule

/* hw/rtl/sba_datapath.sv */
module sba_datapath #(
    parameter int SLOTS = sba_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sba_pkg::t_ctrl                    i_ctrl,
    input  logic [sba_pkg::OP_W-1:0]          i_operation,
    input  logic [sba_pkg::IDX_W-1:0]         i_slot_index,
    input  logic                              i_cfg_valid,
    input  logic [sba_pkg::CFGI_W-1:0]        i_cfg_index,
    input  logic [sba_pkg::ADDR_W-1:0]        i_cfg_data,
    output logic [sba_pkg::STS_W-1:0]         o_status,
    output logic [sba_pkg::GNT_W-1:0]         o_granted_slot,
    output logic [sba_pkg::ADDR_W-1:0]        o_handle_address,
    output logic [sba_pkg::CNT_W-1:0]         o_allocated_count,
    output logic [sba_pkg::CNT_W-1:0]         o_remaining_count
);

    localparam int MAP_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // capacity register tops out at 127, so only that many slots are reachable
    localparam int CAP_LIM = (SLOTS < 127) ? SLOTS : 127;
    localparam int NGRP    = (CAP_LIM + sba_pkg::GRP_W - 1) / sba_pkg::GRP_W;

    // configuration
    logic                         r_enabled;
    logic [sba_pkg::CNT_W-1:0]    r_capacity;
    logic [sba_pkg::STR_W-1:0]    r_stride;
    logic [sba_pkg::ADDR_W-1:0]   r_base;

    // request
    logic [sba_pkg::OP_W-1:0]     r_op;
    logic [sba_pkg::IDX_W-1:0]    r_idx;

    // state
    logic [SLOTS-1:0]             r_map;
    logic [SLOTS-1:0]             n_map;
    logic [sba_pkg::CNT_W-1:0]    r_count;
    logic [sba_pkg::CNT_W-1:0]    n_count;

    // search summary
    logic [NGRP-1:0]              r_grp_any;
    logic [NGRP-1:0]              n_grp_any;
    logic [sba_pkg::LOW_W-1:0]    r_grp_low [NGRP];
    logic [sba_pkg::LOW_W-1:0]    n_grp_low [NGRP];

    // result in flight
    logic [sba_pkg::STS_W-1:0]    r_status;
    logic [sba_pkg::STS_W-1:0]    n_status;
    logic [sba_pkg::GNT_W-1:0]    r_granted;
    logic [sba_pkg::GNT_W-1:0]    n_granted;
    logic                         r_hok;
    logic                         n_hok;
    logic [sba_pkg::IDX_W-1:0]    r_mul_idx;
    logic [sba_pkg::IDX_W-1:0]    n_mul_idx;
    logic [sba_pkg::PROD_W-1:0]   r_prod;

    logic [sba_pkg::CNT_W-1:0]    eff_cap;
    logic                         found;
    logic [sba_pkg::CNT_W-1:0]    slot;
    logic                         idx_ok;

    assign eff_cap = (r_capacity > sba_pkg::CNT_W'(CAP_LIM)) ?
                     sba_pkg::CNT_W'(CAP_LIM) : r_capacity;

    // first step: lowest free slot inside each group of eight
    always_comb begin
        int pos;
        for (int g = 0; g < NGRP; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_low[g] = '0;
            for (int b = sba_pkg::GRP_W - 1; b >= 0; b--) begin
                pos = g * sba_pkg::GRP_W + b;
                if (pos < CAP_LIM && pos < int'(eff_cap) && !r_map[pos]) begin
                    n_grp_any[g] = 1'b1;
                    n_grp_low[g] = sba_pkg::LOW_W'(b);
                end
            end
        end
    end

    // second step: lowest group with a free slot
    always_comb begin
        found = 1'b0;
        slot  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                found = 1'b1;
                slot  = sba_pkg::CNT_W'(g * sba_pkg::GRP_W)
                      + sba_pkg::CNT_W'(r_grp_low[g]);
            end
        end
    end

    assign idx_ok = (r_idx < sba_pkg::IDX_W'(eff_cap));

    always_comb begin
        n_map     = r_map;
        n_count   = r_count;
        n_status  = sba_pkg::ST_OK;
        n_granted = '0;
        n_hok     = 1'b0;
        n_mul_idx = r_idx;
        unique case (r_op)
            sba_pkg::OP_ALLOC: begin
                n_mul_idx = sba_pkg::IDX_W'(slot);
                if (!r_enabled) begin
                    n_status = sba_pkg::ST_DISABLED;
                end else if (r_count >= eff_cap || !found) begin
                    n_status = sba_pkg::ST_FULL;
                end else begin
                    n_map[MAP_IW'(slot)] = 1'b1;
                    n_count   = r_count + sba_pkg::CNT_W'(1);
                    n_granted = slot[sba_pkg::GNT_W-1:0];
                    n_hok     = 1'b1;
                end
            end
            sba_pkg::OP_FREE: begin
                if (!r_enabled) begin
                    n_status = sba_pkg::ST_DISABLED;
                end else if (!idx_ok) begin
                    n_status = sba_pkg::ST_RANGE;
                end else if (!r_map[MAP_IW'(r_idx)]) begin
                    n_status = sba_pkg::ST_NOT_BUSY;
                end else begin
                    n_map[MAP_IW'(r_idx)] = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - sba_pkg::CNT_W'(1);
                    end
                end
            end
            sba_pkg::OP_RESET: begin
                if (!r_enabled) begin
                    n_status = sba_pkg::ST_DISABLED;
                end else begin
                    n_map   = '0;
                    n_count = '0;
                end
            end
            sba_pkg::OP_HANDLE: begin
                if (!idx_ok) begin
                    n_status = sba_pkg::ST_RANGE;
                end else begin
                    n_hok = 1'b1;
                end
            end
            default: n_status = sba_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_capacity <= '0;
            r_stride   <= '0;
            r_base     <= '0;
            r_map      <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sba_pkg::CFG_ENABLED:  r_enabled  <= i_cfg_data[0];
                    sba_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data[sba_pkg::CNT_W-1:0];
                    sba_pkg::CFG_STRIDE:   r_stride   <= i_cfg_data[sba_pkg::STR_W-1:0];
                    sba_pkg::CFG_BASE:     r_base     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctrl.exec) begin
                r_map   <= n_map;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op  <= i_operation;
            r_idx <= i_slot_index;
        end
        if (i_ctrl.scan) begin
            r_grp_any <= n_grp_any;
            r_grp_low <= n_grp_low;
        end
        if (i_ctrl.exec) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_hok     <= n_hok;
            r_mul_idx <= n_mul_idx;
        end
        if (i_ctrl.mul) begin
            r_prod <= sba_pkg::PROD_W'(r_mul_idx) * sba_pkg::PROD_W'(r_stride);
        end
        if (i_ctrl.emit) begin
            o_status          <= r_status;
            o_granted_slot    <= r_granted;
            o_handle_address  <= r_hok ? (r_base + sba_pkg::ADDR_W'(r_prod)) : '0;
            o_allocated_count <= r_count;
            o_remaining_count <= (eff_cap > r_count) ? (eff_cap - r_count) : '0;
        end
    end

endmodule

/* test/slot_alloc_checker.sv */
`timescale 1ns / 1ps
module slot_alloc_checker
    import sba_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [IDX_W-1:0]     i_slot_index,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFGI_W-1:0]    i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_strobe,
    input  logic [STS_W-1:0]     i_status,
    input  logic [GNT_W-1:0]     i_granted_slot,
    input  logic [ADDR_W-1:0]    i_handle_address,
    input  logic [CNT_W-1:0]     i_allocated_count,
    input  logic [CNT_W-1:0]     i_remaining_count,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [GNT_W-1:0]  granted;
        logic [ADDR_W-1:0] handle;
        logic [CNT_W-1:0]  allocated;
        logic [CNT_W-1:0]  remaining;
    } t_slot_result;

    t_slot_result      awaited_results[$];
    logic [SLOTS-1:0]  busy_slots;
    int                busy_total;

    logic              cfg_enabled;
    logic [CNT_W-1:0]  cfg_capacity;
    logic [STR_W-1:0]  cfg_stride;
    logic [ADDR_W-1:0] cfg_base;

    int fail_total = 0;
    int checked_total = 0;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] prod;
        prod = ADDR_W'(idx) * ADDR_W'(cfg_stride);
        return cfg_base + prod;
    endfunction

    task automatic predict_slot_request(input logic [OP_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        output t_slot_result r);
        int cap;
        bit found;
        cap = (int'(cfg_capacity) < SLOTS) ? int'(cfg_capacity) : SLOTS;
        r = '0;
        r.status = ST_OK;
        found = 1'b0;
        case (op)
            OP_ALLOC: begin
                if (!cfg_enabled) begin
                    r.status = ST_DISABLED;
                end else if (busy_total >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    // first fit below the effective capacity
                    r.status = ST_FULL;
                    for (int i = 0; i < cap && !found; i++) begin
                        if (!busy_slots[i]) begin
                            busy_slots[i] = 1'b1;
                            busy_total++;
                            r.granted = GNT_W'(i);
                            r.handle = slot_addr(IDX_W'(i));
                            r.status = ST_OK;
                            found = 1'b1;
                        end
                    end
                end
            end
            OP_FREE: begin
                if (!cfg_enabled) begin
                    r.status = ST_DISABLED;
                end else if (int'(idx) >= cap) begin
                    r.status = ST_RANGE;
                end else if (!busy_slots[idx]) begin
                    r.status = ST_NOT_BUSY;
                end else begin
                    busy_slots[idx] = 1'b0;
                    if (busy_total > 0) busy_total--;
                end
            end
            OP_RESET: begin
                if (!cfg_enabled) begin
                    r.status = ST_DISABLED;
                end else begin
                    busy_slots = '0;
                    busy_total = 0;
                end
            end
            OP_HANDLE: begin
                // allowed while disabled; only the index matters
                if (int'(idx) >= cap) r.status = ST_RANGE;
                else r.handle = slot_addr(idx);
            end
        endcase
        r.allocated = CNT_W'(busy_total);
        r.remaining = (cap > busy_total) ? CNT_W'(cap - busy_total) : '0;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_result want;
        if (!i_rst_n) begin
            busy_slots = '0;
            busy_total = 0;
            cfg_enabled = 1'b0;
            cfg_capacity = '0;
            cfg_stride = '0;
            cfg_base = '0;
            awaited_results.delete();
        end else begin
            // compare first so a word taken on the strobe edge queues behind
            if (i_strobe) begin
                if (awaited_results.size() == 0) begin
                    $error("result strobe with nothing outstanding (status %0d)", i_status);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    checked_total++;
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("granted_slot", 64'(want.granted), 64'(i_granted_slot));
                    check_field("handle_address", 64'(want.handle),
                                64'(i_handle_address));
                    check_field("allocated_count", 64'(want.allocated),
                                64'(i_allocated_count));
                    check_field("remaining_count", 64'(want.remaining),
                                64'(i_remaining_count));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLED:  cfg_enabled = i_cfg_data[0];
                    CFG_CAPACITY: cfg_capacity = i_cfg_data[CNT_W-1:0];
                    CFG_STRIDE:   cfg_stride = i_cfg_data[STR_W-1:0];
                    CFG_BASE:     cfg_base = i_cfg_data;
                endcase
            end
            if (i_start && !i_busy) begin
                predict_slot_request(i_operation, i_slot_index, want);
                awaited_results.push_back(want);
            end
        end
        o_pending = awaited_results.size();
        o_fail_count = fail_total;
        o_checked = checked_total;
    end

endmodule

/* test/slot_bitmap_allocator_test.sv */
`timescale 1ns / 1ps
module slot_bitmap_allocator_test;
    import sba_pkg::*;

    localparam int SEG_WORDS = 120;
    localparam int SEGS_PER_PHASE = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_operation = '0;
    logic [IDX_W-1:0]     i_slot_index = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFGI_W-1:0]    i_cfg_index = '0;
    logic [ADDR_W-1:0]    i_cfg_data = '0;
    logic                 o_strobe;
    logic [STS_W-1:0]     o_status;
    logic [GNT_W-1:0]     o_granted_slot;
    logic [ADDR_W-1:0]    o_handle_address;
    logic [CNT_W-1:0]     o_allocated_count;
    logic [CNT_W-1:0]     o_remaining_count;

    int fail_count;
    int pending;
    int checked;

    int op_count[4] = '{0, 0, 0, 0};
    int settings_count = 0;
    int cur_capacity = 0;

    slot_bitmap_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_slot_index      (i_slot_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_handle_address  (o_handle_address),
        .o_allocated_count (o_allocated_count),
        .o_remaining_count (o_remaining_count)
    );

    slot_alloc_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_operation       (i_operation),
        .i_slot_index      (i_slot_index),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_strobe          (o_strobe),
        .i_status          (o_status),
        .i_granted_slot    (o_granted_slot),
        .i_handle_address  (o_handle_address),
        .i_allocated_count (o_allocated_count),
        .i_remaining_count (o_remaining_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    // called just after a falling edge; start is left high so the next word
    // can follow straight on
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_slot_index <= idx;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        op_count[op]++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic en, input logic [CNT_W-1:0] cap,
                                input logic [STR_W-1:0] stride, input logic [ADDR_W-1:0] base);
        wait_idle();
        write_reg(CFG_ENABLED, ADDR_W'(en));
        write_reg(CFG_CAPACITY, ADDR_W'(cap));
        write_reg(CFG_STRIDE, ADDR_W'(stride));
        write_reg(CFG_BASE, base);
        i_cfg_valid <= 1'b0;
        cur_capacity = int'(cap);
        settings_count++;
    endtask

    task automatic random_regs();
        logic [CNT_W-1:0]  cap;
        logic [STR_W-1:0]  stride;
        logic [ADDR_W-1:0] base;
        case ($urandom_range(7))
            0: cap = '0;
            1: cap = CNT_W'(1);
            2: cap = CNT_W'(64);
            3: cap = CNT_W'(127);
            4: cap = CNT_W'($urandom_range(65, 127));
            5: cap = CNT_W'($urandom_range(0, 64));
            default: cap = CNT_W'($urandom_range(2, 16));
        endcase
        case ($urandom_range(3))
            0: stride = '0;
            1: stride = '1;
            default: stride = STR_W'($urandom);
        endcase
        case ($urandom_range(3))
            0: base = '0;
            1: base = ADDR_MAX;
            default: base = ADDR_W'({$urandom, $urandom});
        endcase
        program_regs($urandom_range(7) != 0, cap, stride, base);
    endtask

    task automatic random_burst(input int n, input int idle_pct);
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        int pick;
        int lim;
        lim = (cur_capacity > 64) ? 64 : cur_capacity;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) op = OP_ALLOC;
            else if (pick < 80) op = OP_FREE;
            else if (pick < 95) op = OP_HANDLE;
            else op = OP_RESET;
            // mostly indexes near the live slots, the range boundary included
            pick = $urandom_range(99);
            if (pick < 70) idx = IDX_W'($urandom_range(0, lim));
            else if (pick < 88) idx = IDX_W'($urandom_range(0, 127));
            else idx = IDX_W'($urandom_range(0, 65535));
            send_request(op, idx, idle_pct);
        end
    endtask

    initial begin
        int drain;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // registers still at reset: disabled and no capacity
        send_request(OP_ALLOC, '0, 0);
        send_request(OP_FREE, '0, 0);
        send_request(OP_RESET, '0, 0);
        send_request(OP_HANDLE, '0, 0);
        send_request(OP_HANDLE, 16'hFFFF, 0);

        // four slots, address wrap past the top of the 48-bit space
        program_regs(1'b1, 7'd4, '1, ADDR_MAX);
        repeat (5) send_request(OP_ALLOC, '0, 0);
        send_request(OP_HANDLE, 16'd3, 0);
        send_request(OP_HANDLE, 16'd4, 0);
        send_request(OP_FREE, 16'd2, 0);
        send_request(OP_FREE, 16'd2, 0);
        send_request(OP_FREE, 16'hFFFF, 0);
        send_request(OP_ALLOC, '0, 0);

        // capacity lowered under busy slots: remaining floors, upper bits stay
        program_regs(1'b1, 7'd2, 10'd1, 48'h0);
        send_request(OP_ALLOC, '0, 0);
        send_request(OP_FREE, 16'd3, 0);
        send_request(OP_FREE, 16'd1, 0);
        send_request(OP_RESET, '0, 0);
        send_request(OP_ALLOC, '0, 0);

        // disabled with oversized capacity: get-handle still served
        program_regs(1'b0, 7'd127, 10'd513, 48'h5555_AAAA_5555);
        send_request(OP_HANDLE, 16'd63, 0);
        send_request(OP_HANDLE, 16'd64, 0);
        send_request(OP_FREE, '0, 0);

        for (int phase = 0; phase < 3; phase++) begin
            for (int s = 0; s < SEGS_PER_PHASE; s++) begin
                random_regs();
                random_burst(SEG_WORDS, (phase == 0) ? 21 : (phase == 1) ? 58 : 0);
            end
        end

        start <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < 2000) begin
            @(negedge i_clk);
            drain++;
        end
        if (pending != 0) begin
            $display("simulation failed");
            $finish;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d allocate, %0d free, %0d reset-all, %0d get-handle requests",
                 op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_RESET],
                 op_count[OP_HANDLE]);
        $display("over %0d register settings; %0d results compared, %0d mismatches",
                 settings_count, checked, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
